/* design/sdsw_pkg.sv */
`default_nettype none
package sdsw_pkg;

	localparam int DIGITS     = 4;
	localparam int IN_SEGS    = 4;
	localparam int LAST_BYTE  = DIGITS + 2;
	localparam int BYTE_IW    = $clog2(LAST_BYTE + 1);
	localparam int SEG_IW     = (DIGITS > 1) ? $clog2(DIGITS) : 1;
	localparam int PHASE_W    = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam logic [PHASE_W-1:0] PHASE_TICKS_RST = 16'd100;
	localparam logic [2:0]         BRIGHTNESS_RST  = 3'd2;
	localparam logic               DISPLAY_ON_RST  = 1'b0;
	localparam logic [7:0]         DATA_CMD_RST    = 8'h40;
	localparam logic [7:0]         ADDR_CMD_RST    = 8'hC0;
	localparam logic [7:0]         CTRL_CMD_RST    = 8'h80;
	localparam logic [2:0]         BRIGHTNESS_MAX  = 3'd7;

	localparam logic OP_TICK  = 1'b0;
	localparam logic OP_WRITE = 1'b1;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_PHASE_TICKS = 3'd0,
		REG_BRIGHTNESS  = 3'd1,
		REG_DISPLAY_ON  = 3'd2,
		REG_DATA_CMD    = 3'd3,
		REG_ADDR_CMD    = 3'd4,
		REG_CTRL_CMD    = 3'd5
	} cfg_reg_t;

	typedef enum logic [3:0] {
		ST_IDLE    = 4'd0,
		ST_START   = 4'd1,
		ST_BIT_LO  = 4'd2,
		ST_BIT_HI  = 4'd3,
		ST_ACK_LO  = 4'd4,
		ST_ACK_HI  = 4'd5,
		ST_ACK_END = 4'd6,
		ST_STOP_A  = 4'd7,
		ST_STOP_B  = 4'd8,
		ST_STOP_C  = 4'd9
	} step_t;

	typedef struct packed {
		logic [PHASE_W-1:0] phase_ticks;
		logic [2:0]         brightness;
		logic               display_on;
		logic [7:0]         data_cmd;
		logic [7:0]         addr_cmd;
		logic [7:0]         ctrl_cmd;
	} cfg_t;

	typedef struct packed {
		logic done;
		logic ack;
		logic busy;
		logic dio;
		logic clk;
	} result_t;

endpackage
`default_nettype wire

/* design/segment_display_serial_writer.sv */
// an accepted input beat is held in the input stage registers, then its result in the result register
// throughput: one beat per cycle while the result register is not stalled; the sequencer state updates once per beat
// s_tready drops only while the result register is full and m_tready is low
// reset: arst_n asynchronous, active low; clears pipeline valids, sequencer and
// configuration registers to their defaults; the segment buffer is not reset
`default_nettype none
module segment_display_serial_writer (
	input  wire                             clk,
	input  wire                             arst_n,
	input  wire                             s_tvalid,
	output logic                            s_tready,
	input  wire  [39:0]                     s_tdata,  // seg_a, seg_b, seg_c, seg_d, dio_sense
	input  wire  [0:0]                      s_tuser,  // op
	output logic                            m_tvalid,
	input  wire                             m_tready,
	output logic [7:0]                      m_tdata,  // clk_level, dio_level, busy_res, ack_level, done_res
	input  wire                             wr_en,
	input  wire  [sdsw_pkg::CFG_IDX_W-1:0]  wr_index,
	input  wire  [sdsw_pkg::CFG_DATA_W-1:0] wr_data
);

	logic              valid_s1;
	logic              op_s1;
	logic [7:0]        segs_s1 [sdsw_pkg::IN_SEGS];
	logic              sense_s1;
	logic              tvalid_s2;
	sdsw_pkg::result_t res_s2;
	sdsw_pkg::result_t res_next;
	sdsw_pkg::cfg_t    cfg;
	logic              advance;

	assign advance  = valid_s1 && (!tvalid_s2 || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			op_s1    <= s_tuser[0];
			for (int i = 0; i < sdsw_pkg::IN_SEGS; i++) begin
				segs_s1[i] <= s_tdata[8*i +: 8];
			end
			sense_s1 <= s_tdata[32];
		end
	end

	sdsw_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (wr_en),
		.wr_index (wr_index),
		.wr_data  (wr_data),
		.cfg      (cfg)
	);

	sdsw_seq u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.advance   (advance),
		.op        (op_s1),
		.segs      (segs_s1),
		.dio_sense (sense_s1),
		.cfg       (cfg),
		.res_next  (res_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tvalid_s2 <= 1'b0;
		end else if (advance) begin
			tvalid_s2 <= 1'b1;
		end else if (m_tready) begin
			tvalid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			res_s2 <= res_next;
		end
	end

	assign m_tvalid = tvalid_s2;
	assign m_tdata  = {3'd0, res_s2.done, res_s2.ack, res_s2.busy, res_s2.dio, res_s2.clk};

endmodule
`default_nettype wire

/* design/sdsw_cfg.sv */
`default_nettype none
module sdsw_cfg (
	input  wire                                 clk,
	input  wire                                 arst_n,
	input  wire                                 wr_en,
	input  wire  [sdsw_pkg::CFG_IDX_W-1:0]      wr_index,
	input  wire  [sdsw_pkg::CFG_DATA_W-1:0]     wr_data,
	output sdsw_pkg::cfg_t                      cfg
);

	sdsw_pkg::cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.phase_ticks <= sdsw_pkg::PHASE_TICKS_RST;
			cfg_q.brightness  <= sdsw_pkg::BRIGHTNESS_RST;
			cfg_q.display_on  <= sdsw_pkg::DISPLAY_ON_RST;
			cfg_q.data_cmd    <= sdsw_pkg::DATA_CMD_RST;
			cfg_q.addr_cmd    <= sdsw_pkg::ADDR_CMD_RST;
			cfg_q.ctrl_cmd    <= sdsw_pkg::CTRL_CMD_RST;
		end else if (wr_en) begin
			case (sdsw_pkg::cfg_reg_t'(wr_index))
				sdsw_pkg::REG_PHASE_TICKS: begin
					cfg_q.phase_ticks <= wr_data[sdsw_pkg::PHASE_W-1:0];
				end
				sdsw_pkg::REG_BRIGHTNESS: begin
					// clamp to the top level
					if (wr_data > sdsw_pkg::CFG_DATA_W'(sdsw_pkg::BRIGHTNESS_MAX)) begin
						cfg_q.brightness <= sdsw_pkg::BRIGHTNESS_MAX;
					end else begin
						cfg_q.brightness <= wr_data[2:0];
					end
				end
				sdsw_pkg::REG_DISPLAY_ON: begin
					cfg_q.display_on <= wr_data[0];
				end
				sdsw_pkg::REG_DATA_CMD: begin
					cfg_q.data_cmd <= wr_data[7:0];
				end
				sdsw_pkg::REG_ADDR_CMD: begin
					cfg_q.addr_cmd <= wr_data[7:0];
				end
				sdsw_pkg::REG_CTRL_CMD: begin
					cfg_q.ctrl_cmd <= wr_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* design/sdsw_seq.sv */
`default_nettype none
module sdsw_seq (
	input  wire                        clk,
	input  wire                        arst_n,
	input  wire                        advance,
	input  wire                        op,
	input  wire  [7:0]                 segs [sdsw_pkg::IN_SEGS],
	input  wire                        dio_sense,
	input  wire  sdsw_pkg::cfg_t       cfg,
	output sdsw_pkg::result_t          res_next
);

	logic [7:0]                   seg_buf_q [sdsw_pkg::DIGITS];
	logic [7:0]                   seg_in    [sdsw_pkg::DIGITS];
	logic                         seg_we;

	sdsw_pkg::step_t              step_q, step_d;
	logic [7:0]                   shift_q, shift_d;
	logic [2:0]                   bit_q, bit_d;
	logic [sdsw_pkg::BYTE_IW-1:0] byte_q, byte_d;
	logic [sdsw_pkg::PHASE_W-1:0] count_q, count_d;
	logic                         clk_q, clk_d;
	logic                         dio_q, dio_d;
	logic                         ack_q, ack_d;
	logic                         done_d;

	logic [sdsw_pkg::PHASE_W-1:0] phase_len;
	logic [sdsw_pkg::PHASE_W-1:0] count_inc;
	logic [sdsw_pkg::BYTE_IW-1:0] byte_nxt;

	// digits past the input fields latch zero
	for (genvar i = 0; i < sdsw_pkg::DIGITS; i++) begin : g_seg_in
		if (i < sdsw_pkg::IN_SEGS) begin : g_field
			assign seg_in[i] = segs[i];
		end else begin : g_zero
			assign seg_in[i] = 8'd0;
		end
	end

	function automatic logic [7:0] byte_at(input logic [sdsw_pkg::BYTE_IW-1:0] idx);
		logic [sdsw_pkg::BYTE_IW-1:0] seg_off;
		seg_off = idx - sdsw_pkg::BYTE_IW'(2);
		if (idx == sdsw_pkg::BYTE_IW'(0)) begin
			return cfg.data_cmd;
		end else if (idx == sdsw_pkg::BYTE_IW'(1)) begin
			return cfg.addr_cmd;
		end else if (idx < sdsw_pkg::BYTE_IW'(2 + sdsw_pkg::DIGITS)) begin
			return seg_buf_q[seg_off[sdsw_pkg::SEG_IW-1:0]];
		end else begin
			return cfg.ctrl_cmd | {4'd0, cfg.display_on, 3'd0} | {5'd0, cfg.brightness};
		end
	endfunction

	function automatic logic frame_ends(input logic [sdsw_pkg::BYTE_IW-1:0] idx);
		return idx == sdsw_pkg::BYTE_IW'(0) ||
			idx == sdsw_pkg::BYTE_IW'(1 + sdsw_pkg::DIGITS) ||
			idx >= sdsw_pkg::BYTE_IW'(sdsw_pkg::LAST_BYTE);
	endfunction

	assign phase_len = (cfg.phase_ticks == '0) ? sdsw_pkg::PHASE_W'(1) : cfg.phase_ticks;
	assign count_inc = count_q + sdsw_pkg::PHASE_W'(1);
	assign byte_nxt  = byte_q + sdsw_pkg::BYTE_IW'(1);

	// next state
	always_comb begin
		step_d  = step_q;
		shift_d = shift_q;
		bit_d   = bit_q;
		byte_d  = byte_q;
		count_d = count_q;
		clk_d   = clk_q;
		dio_d   = dio_q;
		ack_d   = ack_q;
		done_d  = 1'b0;
		seg_we  = 1'b0;
		if (op == sdsw_pkg::OP_WRITE) begin
			if (step_q == sdsw_pkg::ST_IDLE) begin
				seg_we  = 1'b1;
				byte_d  = '0;
				bit_d   = '0;
				shift_d = cfg.data_cmd;
				count_d = '0;
				step_d  = sdsw_pkg::ST_START;
				dio_d   = 1'b0;
			end
		end else if (step_q != sdsw_pkg::ST_IDLE) begin
			if (count_inc >= phase_len) begin
				count_d = '0;
				case (step_q)
					sdsw_pkg::ST_START: begin
						step_d = sdsw_pkg::ST_BIT_LO;
						clk_d  = 1'b0;
					end
					sdsw_pkg::ST_BIT_LO: begin
						step_d = sdsw_pkg::ST_BIT_HI;
						dio_d  = shift_q[0];
						clk_d  = 1'b1;
					end
					sdsw_pkg::ST_BIT_HI: begin
						shift_d = {1'b0, shift_q[7:1]};
						clk_d   = 1'b0;
						if (bit_q == 3'd7) begin
							bit_d  = '0;
							step_d = sdsw_pkg::ST_ACK_LO;
							dio_d  = 1'b1;
						end else begin
							bit_d  = bit_q + 3'd1;
							step_d = sdsw_pkg::ST_BIT_LO;
						end
					end
					sdsw_pkg::ST_ACK_LO: begin
						step_d = sdsw_pkg::ST_ACK_HI;
						clk_d  = 1'b1;
					end
					sdsw_pkg::ST_ACK_HI: begin
						ack_d  = dio_sense;
						step_d = sdsw_pkg::ST_ACK_END;
						clk_d  = 1'b0;
					end
					sdsw_pkg::ST_ACK_END: begin
						if (frame_ends(byte_q)) begin
							step_d = sdsw_pkg::ST_STOP_A;
							dio_d  = 1'b0;
						end else begin
							byte_d  = byte_nxt;
							shift_d = byte_at(byte_nxt);
							step_d  = sdsw_pkg::ST_BIT_LO;
							clk_d   = 1'b0;
						end
					end
					sdsw_pkg::ST_STOP_A: begin
						step_d = sdsw_pkg::ST_STOP_B;
						clk_d  = 1'b1;
					end
					sdsw_pkg::ST_STOP_B: begin
						step_d = sdsw_pkg::ST_STOP_C;
						dio_d  = 1'b1;
					end
					sdsw_pkg::ST_STOP_C: begin
						if (byte_q >= sdsw_pkg::BYTE_IW'(sdsw_pkg::LAST_BYTE)) begin
							step_d = sdsw_pkg::ST_IDLE;
							done_d = 1'b1;
						end else begin
							byte_d  = byte_nxt;
							shift_d = byte_at(byte_nxt);
							step_d  = sdsw_pkg::ST_START;
							dio_d   = 1'b0;
						end
					end
					default: begin
						step_d = sdsw_pkg::ST_IDLE;
					end
				endcase
			end else begin
				count_d = count_inc;
			end
		end
	end

	// outputs
	always_comb begin
		res_next.clk  = clk_d;
		res_next.dio  = dio_d;
		res_next.busy = (step_d != sdsw_pkg::ST_IDLE);
		res_next.ack  = ack_d;
		res_next.done = done_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q  <= sdsw_pkg::ST_IDLE;
			shift_q <= '0;
			bit_q   <= '0;
			byte_q  <= '0;
			count_q <= '0;
			clk_q   <= 1'b0;
			dio_q   <= 1'b0;
			ack_q   <= 1'b0;
		end else if (advance) begin
			step_q  <= step_d;
			shift_q <= shift_d;
			bit_q   <= bit_d;
			byte_q  <= byte_d;
			count_q <= count_d;
			clk_q   <= clk_d;
			dio_q   <= dio_d;
			ack_q   <= ack_d;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && seg_we) begin
			seg_buf_q <= seg_in;
		end
	end

endmodule
`default_nettype wire

/* design/sdsw_checker.sv */
`default_nettype none
module sdsw_checker (
	input wire                             clk,
	input wire                             arst_n,
	input wire                             s_tready,
	input wire                             m_tvalid,
	input wire                             m_tready,
	input wire [7:0]                       m_tdata
);

	// stalled result beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result beat changed while stalled");

	// end of sequence leaves the block idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> !m_tdata[2])
		else $error("done with busy set");

	// end of sequence follows a stop: both lines released
	a_done_lines: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[4] |-> m_tdata[0] && m_tdata[1])
		else $error("done without both lines high");

	// input side is free whenever the result side is free
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!m_tvalid |-> s_tready)
		else $error("input stalled with empty result register");

endmodule

bind segment_display_serial_writer sdsw_checker u_sdsw_checker (.*);
`default_nettype wire
